// File: src/ncofs_pkg.sv
// ----------------------------------------------------------------------------
// ncofs_pkg
// Shared widths, pipeline payload types and the CORDIC arctangent table for
// the NCO complex frequency shifter.
// ----------------------------------------------------------------------------
package ncofs_pkg;

    localparam int PHASE_W      = 21;   // oscillator phase index
    localparam int STEP_W       = 21;   // signed phase step
    localparam int ANGLE_W      = 32;   // angle in 2^-32 turns
    localparam int ROT_W        = 34;   // CORDIC x, y and z datapath
    localparam int CORDIC_STEPS = 24;
    localparam int TRIG_W       = 16;   // cos/sin, Q1.15
    localparam int FRAC_BITS    = 15;

    localparam logic signed [ROT_W-1:0] CORDIC_X0 = 34'sd652032874;

    typedef struct packed {
        logic                     adj;
        logic [PHASE_W-1:0]       phase;
        logic signed [STEP_W-1:0] step;
    } t_tag;

    typedef struct packed {
        logic signed [ROT_W-1:0] x;
        logic signed [ROT_W-1:0] y;
        logic signed [ROT_W-1:0] z;
        logic                    neg;
    } t_rot;

    // round(atan(2^-i) * 2^32 / (2*pi))
    function automatic logic signed [ROT_W-1:0] atan_turn(input int unsigned idx);
        logic signed [ROT_W-1:0] v;
        case (idx)
            0:       v = 34'sd536870912;
            1:       v = 34'sd316933406;
            2:       v = 34'sd167458907;
            3:       v = 34'sd85004756;
            4:       v = 34'sd42667331;
            5:       v = 34'sd21354465;
            6:       v = 34'sd10679838;
            7:       v = 34'sd5340245;
            8:       v = 34'sd2670163;
            9:       v = 34'sd1335087;
            10:      v = 34'sd667544;
            11:      v = 34'sd333772;
            12:      v = 34'sd166886;
            13:      v = 34'sd83443;
            14:      v = 34'sd41722;
            15:      v = 34'sd20861;
            16:      v = 34'sd10430;
            17:      v = 34'sd5215;
            18:      v = 34'sd2608;
            19:      v = 34'sd1304;
            20:      v = 34'sd652;
            21:      v = 34'sd326;
            22:      v = 34'sd163;
            23:      v = 34'sd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: src/nco_complex_frequency_shifter.sv
// ----------------------------------------------------------------------------
// nco_complex_frequency_shifter
// Mixes a complex I/Q stream with a CORDIC-based numerically controlled
// oscillator whose phase step is adjusted in-band.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: tuser[0] = 1 makes the item an adjust, whose offset_delta
//   is added to the phase step with saturation; tuser[0] = 0 makes it a
//   sample, mixed with cos + j*sin of the current phase, after which the
//   phase steps down by the phase step, modulo PHASE_MODULUS.
//   Output stream: one result per item, in order. An adjust returns zero
//   samples with the current phase and the new phase step.
//   Throughput: one item per clock while the output is not stalled. The phase
//   recurrence closes in the input register stage; the oscillator and mixer
//   behind it are fully pipelined.
//   Pipeline: an accepted item passes through 30 register stages: input
//   register, two stages of reciprocal multiply and quadrant fold, 24 CORDIC
//   stages, and three stages of rounding, multiply and output saturation.
//   Stall: every stage holds its own valid bit, so a stalled receiver only
//   blocks the input once all stages are full; bubbles collapse meanwhile.
//   Reset: synchronous, active low; clears phase, phase step and all valid
//   bits. Items in flight are dropped.
// ----------------------------------------------------------------------------
module nco_complex_frequency_shifter #(
    parameter int PHASE_MODULUS = 2048000,
    parameter int SAMPLE_BITS   = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // sample_i, sample_q, offset_delta, zero padding
    input  logic [((2*SAMPLE_BITS+ncofs_pkg::STEP_W+7)/8)*8-1:0] s_axis_tdata,
    // req_type
    input  logic [0:0]                s_axis_tuser,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // out_i, out_q, phase_used, offset_now, zero padding
    output logic [((2*SAMPLE_BITS+ncofs_pkg::PHASE_W+ncofs_pkg::STEP_W+7)/8)*8-1:0]
                                      m_axis_tdata
);
    localparam int SB       = SAMPLE_BITS;
    localparam int NS       = ncofs_pkg::CORDIC_STEPS;
    localparam int OUT_BITS = 2 * SB + ncofs_pkg::PHASE_W + ncofs_pkg::STEP_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;
    localparam int STEP_LIM = PHASE_MODULUS / 2 - 1;

    logic                 w_ctl_vld, w_ctl_rdy;
    ncofs_pkg::t_tag      w_ctl_tag;
    logic signed [SB-1:0] w_ctl_si, w_ctl_sq;

    logic                 w_cv   [NS+1];
    logic                 w_crdy [NS+1];
    ncofs_pkg::t_tag      w_ctag [NS+1];
    ncofs_pkg::t_rot      w_crot [NS+1];
    logic signed [SB-1:0] w_csi  [NS+1];
    logic signed [SB-1:0] w_csq  [NS+1];

    ncofs_pkg::t_tag      w_out_tag;
    logic signed [SB-1:0] w_out_i, w_out_q;

    ncofs_phase_ctrl #(
        .PHASE_MODULUS (PHASE_MODULUS),
        .SAMPLE_BITS   (SAMPLE_BITS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_adj   (s_axis_tuser[0]),
        .i_si    (s_axis_tdata[SB-1:0]),
        .i_sq    (s_axis_tdata[2*SB-1:SB]),
        .i_delta (s_axis_tdata[2*SB +: ncofs_pkg::STEP_W]),
        .o_valid (w_ctl_vld),
        .i_ready (w_ctl_rdy),
        .o_tag   (w_ctl_tag),
        .o_si    (w_ctl_si),
        .o_sq    (w_ctl_sq)
    );

    ncofs_angle #(
        .PHASE_MODULUS (PHASE_MODULUS),
        .SAMPLE_BITS   (SAMPLE_BITS)
    ) u_angle (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_ctl_vld),
        .o_ready (w_ctl_rdy),
        .i_tag   (w_ctl_tag),
        .i_si    (w_ctl_si),
        .i_sq    (w_ctl_sq),
        .o_valid (w_cv[0]),
        .i_ready (w_crdy[0]),
        .o_tag   (w_ctag[0]),
        .o_rot   (w_crot[0]),
        .o_si    (w_csi[0]),
        .o_sq    (w_csq[0])
    );

    for (genvar k = 0; k < NS; k++) begin : g_cordic
        ncofs_cordic_stage #(
            .STEP        (k),
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_cv[k]),
            .o_ready (w_crdy[k]),
            .i_tag   (w_ctag[k]),
            .i_rot   (w_crot[k]),
            .i_si    (w_csi[k]),
            .i_sq    (w_csq[k]),
            .o_valid (w_cv[k+1]),
            .i_ready (w_crdy[k+1]),
            .o_tag   (w_ctag[k+1]),
            .o_rot   (w_crot[k+1]),
            .o_si    (w_csi[k+1]),
            .o_sq    (w_csq[k+1])
        );
    end

    ncofs_mixer #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mixer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_cv[NS]),
        .o_ready (w_crdy[NS]),
        .i_tag   (w_ctag[NS]),
        .i_rot   (w_crot[NS]),
        .i_si    (w_csi[NS]),
        .i_sq    (w_csq[NS]),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_tag   (w_out_tag),
        .o_out_i (w_out_i),
        .o_out_q (w_out_q)
    );

    assign m_axis_tdata = OUT_W'({w_out_tag.step, w_out_tag.phase, w_out_q, w_out_i});

`ifndef ASSERT_OFF
    // the phase handed to the oscillator always lies inside the modulus
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl_vld |-> (32'(w_ctl_tag.phase) < PHASE_MODULUS))
        else $error("phase index outside modulus");

    // the reported phase step never leaves its saturation limits
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((int'(w_out_tag.step) <= STEP_LIM)
                        && (int'(w_out_tag.step) >= -STEP_LIM)))
        else $error("phase step outside saturation limits");

    // input back-pressure only arises from a stalled, occupied output
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without output back-pressure");
`endif

endmodule

// File: src/ncofs_phase_ctrl.sv
// ----------------------------------------------------------------------------
// ncofs_phase_ctrl
// Input register with the phase accumulator and the saturating phase step.
// ----------------------------------------------------------------------------
module ncofs_phase_ctrl #(
    parameter int PHASE_MODULUS = 2048000,
    parameter int SAMPLE_BITS   = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic                                 i_adj,
    input  logic signed [SAMPLE_BITS-1:0]        i_si,
    input  logic signed [SAMPLE_BITS-1:0]        i_sq,
    input  logic signed [ncofs_pkg::STEP_W-1:0]  i_delta,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output ncofs_pkg::t_tag                      o_tag,
    output logic signed [SAMPLE_BITS-1:0]        o_si,
    output logic signed [SAMPLE_BITS-1:0]        o_sq
);
    localparam int SUM_W  = ncofs_pkg::STEP_W + 1;
    localparam int DIFF_W = ncofs_pkg::PHASE_W + 2;
    localparam logic signed [SUM_W-1:0]  LIM  = SUM_W'(PHASE_MODULUS / 2 - 1);
    localparam logic signed [SUM_W-1:0]  NLIM = -LIM;
    localparam logic signed [DIFF_W-1:0] MOD  = DIFF_W'(PHASE_MODULUS);

    logic [ncofs_pkg::PHASE_W-1:0]       r_phase, n_phase;
    logic signed [ncofs_pkg::STEP_W-1:0] r_step, n_step;
    logic                                r_vld;
    ncofs_pkg::t_tag                     r_tag;
    logic signed [SAMPLE_BITS-1:0]       r_si, r_sq;

    logic                                w_accept;
    logic signed [SUM_W-1:0]             w_sum;
    logic signed [ncofs_pkg::STEP_W-1:0] w_step_sat;
    logic signed [DIFF_W-1:0]            w_diff;
    logic signed [DIFF_W-1:0]            w_wrap;

    assign o_ready  = !r_vld || i_ready;
    assign w_accept = i_valid && o_ready;

    always_comb begin
        w_sum = $signed({r_step[ncofs_pkg::STEP_W-1], r_step})
              + $signed({i_delta[ncofs_pkg::STEP_W-1], i_delta});
        if (w_sum > LIM) begin
            w_step_sat = LIM[ncofs_pkg::STEP_W-1:0];
        end else if (w_sum < NLIM) begin
            w_step_sat = NLIM[ncofs_pkg::STEP_W-1:0];
        end else begin
            w_step_sat = w_sum[ncofs_pkg::STEP_W-1:0];
        end
    end

    // step down by the phase step and fold back into [0, modulus)
    always_comb begin
        w_diff = $signed({2'b00, r_phase})
               - $signed({{2{r_step[ncofs_pkg::STEP_W-1]}}, r_step});
        if (w_diff < 0) begin
            w_wrap = w_diff + MOD;
        end else if (w_diff >= MOD) begin
            w_wrap = w_diff - MOD;
        end else begin
            w_wrap = w_diff;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_step  = r_step;
        if (w_accept) begin
            if (i_adj) begin
                n_step = w_step_sat;
            end else begin
                n_phase = w_wrap[ncofs_pkg::PHASE_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= 1'b0;
            r_phase <= '0;
            r_step  <= '0;
        end else begin
            if (o_ready) begin
                r_vld <= i_valid;
            end
            r_phase <= n_phase;
            r_step  <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_tag.adj   <= i_adj;
            r_tag.phase <= r_phase;
            r_tag.step  <= i_adj ? w_step_sat : r_step;
            r_si        <= i_si;
            r_sq        <= i_sq;
        end
    end

    assign o_valid = r_vld;
    assign o_tag   = r_tag;
    assign o_si    = r_si;
    assign o_sq    = r_sq;

endmodule

// File: src/ncofs_angle.sv
// ----------------------------------------------------------------------------
// ncofs_angle
// Phase index to angle in 2^-32 turns by reciprocal multiplication, then
// quadrant fold into the CORDIC convergence range. Two pipeline stages.
// ----------------------------------------------------------------------------
module ncofs_angle #(
    parameter int PHASE_MODULUS = 2048000,
    parameter int SAMPLE_BITS   = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  ncofs_pkg::t_tag               i_tag,
    input  logic signed [SAMPLE_BITS-1:0] i_si,
    input  logic signed [SAMPLE_BITS-1:0] i_sq,
    output logic                          o_valid,
    input  logic                          i_ready,
    output ncofs_pkg::t_tag               o_tag,
    output ncofs_pkg::t_rot               o_rot,
    output logic signed [SAMPLE_BITS-1:0] o_si,
    output logic signed [SAMPLE_BITS-1:0] o_sq
);
    localparam int LOG_M   = $clog2(PHASE_MODULUS);
    localparam int RSH     = 2 * LOG_M;
    localparam int RECIP_W = ncofs_pkg::ANGLE_W + 2 + LOG_M;
    localparam int LO_W    = (RECIP_W + 1) / 2;
    localparam int HI_W    = RECIP_W - LO_W;
    localparam int PLO_W   = ncofs_pkg::PHASE_W + LO_W;
    localparam int PHI_W   = ncofs_pkg::PHASE_W + HI_W;
    localparam int PROD_W  = ncofs_pkg::PHASE_W + RECIP_W;
    localparam int AW      = ncofs_pkg::ANGLE_W;
    localparam int RW      = ncofs_pkg::ROT_W;

    // ceil(2^(32+RSH) / modulus): exact floor for every phase below the modulus
    localparam logic [127:0] RECIP_FULL =
        ((128'd1 << (AW + RSH)) + 128'(PHASE_MODULUS) - 128'd1) / 128'(PHASE_MODULUS);
    localparam logic [RECIP_W-1:0] RECIP    = RECIP_FULL[RECIP_W-1:0];
    localparam logic [LO_W-1:0]    RECIP_LO = RECIP[LO_W-1:0];
    localparam logic [HI_W-1:0]    RECIP_HI = RECIP[RECIP_W-1:LO_W];

    logic                          r1_vld, r2_vld;
    logic [PLO_W-1:0]              r1_lo;
    logic [PHI_W-1:0]              r1_hi;
    ncofs_pkg::t_tag               r1_tag, r2_tag;
    logic signed [SAMPLE_BITS-1:0] r1_si, r1_sq, r2_si, r2_sq;
    ncofs_pkg::t_rot               r2_rot;

    logic                          w_rdy1;
    logic [PROD_W-1:0]             w_prod;
    logic [AW-1:0]                 w_ang;
    logic                          w_neg;
    logic [AW-1:0]                 w_zs;
    ncofs_pkg::t_rot               w_rot;

    assign w_rdy1  = !r2_vld || i_ready;
    assign o_ready = !r1_vld || w_rdy1;

    always_comb begin
        w_prod = (PROD_W'(r1_hi) << LO_W) + PROD_W'(r1_lo);
        w_ang  = w_prod[RSH +: AW];
        // second and third quadrant: rotate by half a turn and negate at the end
        w_neg  = w_ang[AW-1] ^ w_ang[AW-2];
        w_zs   = {w_ang[AW-1] ^ w_neg, w_ang[AW-2:0]};
        w_rot.x   = ncofs_pkg::CORDIC_X0;
        w_rot.y   = '0;
        w_rot.z   = {{(RW - AW){w_zs[AW-1]}}, w_zs};
        w_rot.neg = w_neg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
        end else begin
            if (o_ready) begin
                r1_vld <= i_valid;
            end
            if (w_rdy1) begin
                r2_vld <= r1_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r1_lo  <= PLO_W'(i_tag.phase) * PLO_W'(RECIP_LO);
            r1_hi  <= PHI_W'(i_tag.phase) * PHI_W'(RECIP_HI);
            r1_tag <= i_tag;
            r1_si  <= i_si;
            r1_sq  <= i_sq;
        end
        if (r1_vld && w_rdy1) begin
            r2_rot <= w_rot;
            r2_tag <= r1_tag;
            r2_si  <= r1_si;
            r2_sq  <= r1_sq;
        end
    end

    assign o_valid = r2_vld;
    assign o_tag   = r2_tag;
    assign o_rot   = r2_rot;
    assign o_si    = r2_si;
    assign o_sq    = r2_sq;

endmodule

// File: src/ncofs_cordic_stage.sv
// ----------------------------------------------------------------------------
// ncofs_cordic_stage
// One registered CORDIC rotation step, shift amount fixed by STEP.
// ----------------------------------------------------------------------------
module ncofs_cordic_stage #(
    parameter int STEP        = 0,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  ncofs_pkg::t_tag               i_tag,
    input  ncofs_pkg::t_rot               i_rot,
    input  logic signed [SAMPLE_BITS-1:0] i_si,
    input  logic signed [SAMPLE_BITS-1:0] i_sq,
    output logic                          o_valid,
    input  logic                          i_ready,
    output ncofs_pkg::t_tag               o_tag,
    output ncofs_pkg::t_rot               o_rot,
    output logic signed [SAMPLE_BITS-1:0] o_si,
    output logic signed [SAMPLE_BITS-1:0] o_sq
);
    localparam logic signed [ncofs_pkg::ROT_W-1:0] TURN = ncofs_pkg::atan_turn(STEP);

    logic                                 r_vld;
    ncofs_pkg::t_tag                      r_tag;
    ncofs_pkg::t_rot                      r_rot;
    logic signed [SAMPLE_BITS-1:0]        r_si, r_sq;

    logic signed [ncofs_pkg::ROT_W-1:0]   w_xs, w_ys;
    ncofs_pkg::t_rot                      n_rot;

    assign o_ready = !r_vld || i_ready;

    always_comb begin
        w_xs      = $signed(i_rot.x) >>> STEP;
        w_ys      = $signed(i_rot.y) >>> STEP;
        n_rot.neg = i_rot.neg;
        if (!i_rot.z[ncofs_pkg::ROT_W-1]) begin
            n_rot.x = i_rot.x - w_ys;
            n_rot.y = i_rot.y + w_xs;
            n_rot.z = i_rot.z - TURN;
        end else begin
            n_rot.x = i_rot.x + w_ys;
            n_rot.y = i_rot.y - w_xs;
            n_rot.z = i_rot.z + TURN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_rot <= n_rot;
            r_tag <= i_tag;
            r_si  <= i_si;
            r_sq  <= i_sq;
        end
    end

    assign o_valid = r_vld;
    assign o_tag   = r_tag;
    assign o_rot   = r_rot;
    assign o_si    = r_si;
    assign o_sq    = r_sq;

endmodule

// File: src/ncofs_mixer.sv
// ----------------------------------------------------------------------------
// ncofs_mixer
// Rounds the CORDIC vector to Q1.15 cos/sin, forms the complex product and
// rounds and saturates it into the output register. Three pipeline stages.
// ----------------------------------------------------------------------------
module ncofs_mixer #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  ncofs_pkg::t_tag               i_tag,
    input  ncofs_pkg::t_rot               i_rot,
    input  logic signed [SAMPLE_BITS-1:0] i_si,
    input  logic signed [SAMPLE_BITS-1:0] i_sq,
    output logic                          o_valid,
    input  logic                          i_ready,
    output ncofs_pkg::t_tag               o_tag,
    output logic signed [SAMPLE_BITS-1:0] o_out_i,
    output logic signed [SAMPLE_BITS-1:0] o_out_q
);
    localparam int RW     = ncofs_pkg::ROT_W;
    localparam int TW     = ncofs_pkg::TRIG_W;
    localparam int PROD_W = SAMPLE_BITS + TW;
    localparam int ACC_W  = PROD_W + 2;
    localparam logic signed [RW-1:0]    RND_ROT  = RW'(1 << (ncofs_pkg::FRAC_BITS - 1));
    localparam logic signed [RW-1:0]    TRIG_MAX = RW'(2 ** (TW - 1) - 1);
    localparam logic signed [ACC_W-1:0] RND_ACC  = ACC_W'(1 << (ncofs_pkg::FRAC_BITS - 1));
    localparam logic signed [ACC_W-1:0] SMAX     = ACC_W'(2 ** (SAMPLE_BITS - 1) - 1);
    localparam logic signed [ACC_W-1:0] SMIN     = -SMAX - ACC_W'(1);

    function automatic logic signed [TW-1:0] trig_round(input logic signed [RW-1:0] v);
        logic signed [RW-1:0] r;
        logic signed [TW-1:0] s;
        r = (v + RND_ROT) >>> ncofs_pkg::FRAC_BITS;
        if (r > TRIG_MAX) begin
            s = TRIG_MAX[TW-1:0];
        end else if (r < -TRIG_MAX) begin
            s = -TRIG_MAX[TW-1:0];
        end else begin
            s = r[TW-1:0];
        end
        return s;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] out_round(
        input logic signed [ACC_W-1:0] v
    );
        logic signed [ACC_W-1:0]       r;
        logic signed [SAMPLE_BITS-1:0] s;
        r = (v + RND_ACC) >>> ncofs_pkg::FRAC_BITS;
        if (r > SMAX) begin
            s = SMAX[SAMPLE_BITS-1:0];
        end else if (r < SMIN) begin
            s = SMIN[SAMPLE_BITS-1:0];
        end else begin
            s = r[SAMPLE_BITS-1:0];
        end
        return s;
    endfunction

    logic                          rt_vld, rm_vld, ro_vld;
    ncofs_pkg::t_tag               rt_tag, rm_tag, ro_tag;
    logic signed [SAMPLE_BITS-1:0] rt_si, rt_sq;
    logic signed [TW-1:0]          rt_c, rt_s;
    logic signed [PROD_W-1:0]      rm_ic, rm_qs, rm_is, rm_qc;
    logic signed [SAMPLE_BITS-1:0] ro_i, ro_q;

    logic                          w_rdy_t, w_rdy_m, w_rdy_o;
    logic signed [RW-1:0]          w_x, w_y;
    logic signed [ACC_W-1:0]       w_re, w_im;

    assign w_rdy_o = !ro_vld || i_ready;
    assign w_rdy_m = !rm_vld || w_rdy_o;
    assign w_rdy_t = !rt_vld || w_rdy_m;
    assign o_ready = w_rdy_t;

    always_comb begin
        w_x  = i_rot.neg ? -i_rot.x : i_rot.x;
        w_y  = i_rot.neg ? -i_rot.y : i_rot.y;
        w_re = ACC_W'(rm_ic) - ACC_W'(rm_qs);
        w_im = ACC_W'(rm_is) + ACC_W'(rm_qc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rt_vld <= 1'b0;
            rm_vld <= 1'b0;
            ro_vld <= 1'b0;
        end else begin
            if (w_rdy_t) begin
                rt_vld <= i_valid;
            end
            if (w_rdy_m) begin
                rm_vld <= rt_vld;
            end
            if (w_rdy_o) begin
                ro_vld <= rm_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && w_rdy_t) begin
            rt_c   <= trig_round(w_x);
            rt_s   <= trig_round(w_y);
            rt_tag <= i_tag;
            rt_si  <= i_si;
            rt_sq  <= i_sq;
        end
        if (rt_vld && w_rdy_m) begin
            rm_ic  <= rt_si * rt_c;
            rm_qs  <= rt_sq * rt_s;
            rm_is  <= rt_si * rt_s;
            rm_qc  <= rt_sq * rt_c;
            rm_tag <= rt_tag;
        end
        if (rm_vld && w_rdy_o) begin
            // an adjust result carries no sample
            ro_i   <= rm_tag.adj ? '0 : out_round(w_re);
            ro_q   <= rm_tag.adj ? '0 : out_round(w_im);
            ro_tag <= rm_tag;
        end
    end

    assign o_valid = ro_vld;
    assign o_tag   = ro_tag;
    assign o_out_i = ro_i;
    assign o_out_q = ro_q;

endmodule
